// File: design/rre_pkg.sv
// Shared types, constants and the pixel operation of the rectangle raster engine.
package rre_pkg;

    localparam int RRE_MAX_WIDTH  = 512;
    localparam int RRE_MAX_HEIGHT = 256;

    localparam int COORD_W  = 10;
    localparam int WIDTH_W  = 10;
    localparam int HEIGHT_W = 9;
    localparam int PIXEL_W  = 8;
    localparam int MODE_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [WIDTH_W-1:0]  SCREEN_WIDTH_RESET  = 10'd320;
    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RESET = 9'd200;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OUTLINE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DARKEN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 3'd4;

    localparam logic [3:0] NIBBLE_MAX    = 4'hF;
    localparam logic [4:0] BRIGHTEN_STEP = 5'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] x_left;
        logic [COORD_W-1:0] y_top;
        logic [COORD_W-1:0] x_right;
        logic [COORD_W-1:0] y_bottom;
        logic [PIXEL_W-1:0] color;
    } rre_cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] read_value;
        logic               clipped;
    } rre_rsp_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic rd_issue;
        logic scan;
        logic clear;
        logic finish;
    } rre_ctl_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic is_paint;
        logic clip;
        logic last_pixel;
        logic out_free;
    } rre_sts_t;

    function automatic logic [PIXEL_W-1:0] rre_pixel_op(
        input logic [MODE_W-1:0]  mode,
        input logic [PIXEL_W-1:0] old,
        input logic [PIXEL_W-1:0] color
    );
        logic [4:0]         lo_sum;
        logic [PIXEL_W-1:0] result;
        lo_sum = {1'b0, old[3:0]} + BRIGHTEN_STEP;
        case (mode)
            MODE_DARKEN:   result = {old[7:4], 1'b0, old[3:1]};
            MODE_BRIGHTEN: result = {old[7:4], (lo_sum > {1'b0, NIBBLE_MAX}) ? NIBBLE_MAX
                                                                          : lo_sum[3:0]};
            default:       result = color;
        endcase
        return result;
    endfunction

endpackage

// File: design/rre_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rre_ctrl.sv
// Sequencing state machine of the rectangle raster engine.
module rre_ctrl
    import rre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    output rre_ctl_t ctl,
    input  rre_sts_t sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                ctl.setup = 1'b1;
                if (sts.is_read)
                begin
                    state_next = ST_READ;
                end
                else if (sts.is_paint && !sts.clip)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = ST_DONE;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.last_pixel)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.setup, ctl.rd_issue, ctl.scan, ctl.clear, ctl.finish}))
        else $error("More than one datapath command in a cycle.");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan && sts.last_pixel |=> state_reg == ST_DONE)
        else $error("Scan did not stop after the last pixel.");

    a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !ctl.load && !cmd_ready)
        else $error("A word was taken during the clearing pass.");

endmodule

// File: design/rre_datapath.sv
// Datapath of the rectangle raster engine: command latch, scan counters and frame store.
module rre_datapath
    import rre_pkg::*;
#(
    parameter int MAX_WIDTH  = RRE_MAX_WIDTH,
    parameter int MAX_HEIGHT = RRE_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rre_cmd_t            cmd,
    input  logic [WIDTH_W-1:0]  eff_width,
    input  logic [HEIGHT_W-1:0] eff_height,
    input  rre_ctl_t            ctl,
    output rre_sts_t            sts,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rre_rsp_t            rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    rre_cmd_t            cmd_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  x_next;
    logic [COORD_W-1:0]  y_reg;
    logic [COORD_W-1:0]  y_next;
    logic [AW-1:0]       row_base_reg;
    logic [AW-1:0]       row_base_next;
    logic                pend_valid_reg;
    logic [AW-1:0]       pend_addr_reg;
    logic [AW-1:0]       clr_reg;
    rre_rsp_t            rsp_reg;
    rre_rsp_t            rsp_next;
    logic                rsp_valid_reg;

    logic [2*COORD_W-1:0] base_prod;
    logic [AW-1:0]        pix_addr;
    logic                 border_row;
    logic                 read_on_screen;
    logic                 rect_bad;
    logic                 is_read;
    logic                 is_paint;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [PIXEL_W-1:0]   ram_wdata;
    logic [PIXEL_W-1:0]   ram_rdata;

    assign base_prod = {{COORD_W{1'b0}}, cmd_reg.y_top}
                     * {{(2*COORD_W-WIDTH_W){1'b0}}, eff_width};
    assign pix_addr  = row_base_reg + AW'(x_reg);

    assign is_read  = (cmd_reg.mode == MODE_READ);
    assign is_paint = cmd_reg.mode inside {MODE_OUTLINE, MODE_FILL, MODE_DARKEN, MODE_BRIGHTEN};

    assign read_on_screen = (cmd_reg.x_left < eff_width)
                         && (cmd_reg.y_top < {1'b0, eff_height});
    assign rect_bad = (cmd_reg.x_left >= eff_width)
                   || (cmd_reg.y_top >= {1'b0, eff_height})
                   || (cmd_reg.x_right >= eff_width)
                   || (cmd_reg.y_bottom >= {1'b0, eff_height})
                   || (cmd_reg.x_right < cmd_reg.x_left)
                   || (cmd_reg.y_bottom < cmd_reg.y_top);

    assign border_row = (y_reg == cmd_reg.y_top) || (y_reg == cmd_reg.y_bottom);

    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        row_base_next = row_base_reg;
        if (ctl.setup)
        begin
            x_next        = cmd_reg.x_left;
            y_next        = cmd_reg.y_top;
            row_base_next = AW'(base_prod);
        end
        else if (ctl.scan)
        begin
            if (x_reg == cmd_reg.x_right)
            begin
                x_next        = cmd_reg.x_left;
                y_next        = y_reg + 1'b1;
                row_base_next = row_base_reg + AW'(eff_width);
            end
            else if ((cmd_reg.mode == MODE_OUTLINE) && !border_row
                     && (x_reg == cmd_reg.x_left))
            begin
                // Interior rows of an outline only touch the two side columns.
                x_next = cmd_reg.x_right;
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_next.read_value = (is_read && read_on_screen) ? ram_rdata : '0;
        rsp_next.clipped    = is_paint && rect_bad;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
        x_reg         <= x_next;
        y_reg         <= y_next;
        row_base_reg  <= row_base_next;
        pend_addr_reg <= pix_addr;
        if (ctl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            clr_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= ctl.scan;
            if (ctl.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Each pixel is read and is written back, modified, in the next cycle.
    assign ram_we    = ctl.clear || pend_valid_reg;
    assign ram_waddr = ctl.clear ? clr_reg : pend_addr_reg;
    assign ram_wdata = ctl.clear ? '0 : rre_pixel_op(cmd_reg.mode, ram_rdata, cmd_reg.color);

    rre_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.scan || ctl.rd_issue),
        .raddr (pix_addr),
        .rdata (ram_rdata)
    );

    assign sts.clear_done = (clr_reg == AW'(DEPTH - 1));
    assign sts.is_read    = is_read;
    assign sts.is_paint   = is_paint;
    assign sts.clip       = rect_bad;
    assign sts.last_pixel = (x_reg == cmd_reg.x_right) && (y_reg == cmd_reg.y_bottom);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !ctl.clear)
        else $error("Pixel write-back collided with the clearing pass.");

    a_drained_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !pend_valid_reg)
        else $error("New word taken while a pixel write-back was pending.");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> rsp_valid_reg)
        else $error("Finished result was not presented.");

endmodule

// File: design/rect_raster_engine.sv
// Top level of the rectangle raster engine: configuration registers and block wiring.
//
//  Channel   Signals                                    Word
//  command   cmd_valid, cmd_ready, cmd                  rre_cmd_t
//  result    rsp_valid, rsp_ready, rsp                  rre_rsp_t
//  config    psel, penable, pwrite, paddr, pwdata,      screen_width, screen_height
//            prdata, pready
//
// After reset the frame store, MAX_WIDTH * MAX_HEIGHT bytes (131072 at the defaults), is
// cleared one byte a cycle, and no command word is taken meanwhile.
// A paint command is set up and then visits each pixel once, making one frame store read
// and one write per cycle: the whole area for fill, darken and brighten, the border only
// for outline. A read is set up and reads one pixel; a refused command is only set up.
// A result waits in its register until taken; the next word is taken once it is there.
module rect_raster_engine
    import rre_pkg::*;
#(
    parameter int MAX_WIDTH  = RRE_MAX_WIDTH,
    parameter int MAX_HEIGHT = RRE_MAX_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  rre_cmd_t           cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rre_rsp_t           rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [WIDTH_W-1:0]  screen_width_reg;
    logic [HEIGHT_W-1:0] screen_height_reg;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic                cfg_write;
    rre_ctl_t            ctl;
    rre_sts_t            sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SCREEN_WIDTH)
            begin
                screen_width_reg <= pwdata[WIDTH_W-1:0];
            end
            else
            begin
                screen_height_reg <= pwdata[HEIGHT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SCREEN_HEIGHT)
                  ? {{(PDATA_W-HEIGHT_W){1'b0}}, screen_height_reg}
                  : {{(PDATA_W-WIDTH_W){1'b0}}, screen_width_reg};

    // The visible area is limited to the size of the frame store.
    assign eff_width  = ({{(32-WIDTH_W){1'b0}}, screen_width_reg} > 32'(MAX_WIDTH))
                      ? WIDTH_W'(MAX_WIDTH) : screen_width_reg;
    assign eff_height = ({{(32-HEIGHT_W){1'b0}}, screen_height_reg} > 32'(MAX_HEIGHT))
                      ? HEIGHT_W'(MAX_HEIGHT) : screen_height_reg;

    rre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    rre_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .ctl        (ctl),
        .sts        (sts),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the rectangle raster engine: predicted frame store and scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rre_pkg::*;

    localparam int STORE_DEPTH = RRE_MAX_WIDTH * RRE_MAX_HEIGHT;

    class raster_scoreboard;
        bit [PIXEL_W-1:0]    pixels [STORE_DEPTH];
        logic [WIDTH_W-1:0]  screen_width;
        logic [HEIGHT_W-1:0] screen_height;
        rre_rsp_t            expected_q [$];
        int                  mismatches;

        function new();
            screen_width  = SCREEN_WIDTH_RESET;
            screen_height = SCREEN_HEIGHT_RESET;
            mismatches    = 0;
        endfunction

        function void write_register(logic idx, logic [PDATA_W-1:0] data);
            if (idx == REG_SCREEN_WIDTH)
                screen_width = data[WIDTH_W-1:0];
            else
                screen_height = data[HEIGHT_W-1:0];
        endfunction

        function int eff_width();
            return (screen_width > RRE_MAX_WIDTH) ? RRE_MAX_WIDTH : int'(screen_width);
        endfunction

        function int eff_height();
            return (screen_height > RRE_MAX_HEIGHT) ? RRE_MAX_HEIGHT : int'(screen_height);
        endfunction

        function bit [PIXEL_W-1:0] shade(logic [MODE_W-1:0] mode, bit [PIXEL_W-1:0] old,
                                         logic [PIXEL_W-1:0] color);
            int lo;
            lo = int'(old[3:0]);
            if (mode == MODE_DARKEN)
                return (old & 8'hF0) | PIXEL_W'(lo >> 1);
            if (mode == MODE_BRIGHTEN)
                return (old & 8'hF0) | PIXEL_W'((lo + 2 > 15) ? 15 : lo + 2);
            return color;
        endfunction

        function void note_command(rre_cmd_t c);
            int       w;
            int       h;
            int       xl;
            int       yt;
            int       xr;
            int       yb;
            int       addr;
            bit       interior;
            rre_rsp_t r;
            w  = eff_width();
            h  = eff_height();
            xl = int'(c.x_left);
            yt = int'(c.y_top);
            xr = int'(c.x_right);
            yb = int'(c.y_bottom);
            r  = '0;
            if (c.mode == MODE_READ) begin
                if (xl < w && yt < h)
                    r.read_value = pixels[yt * w + xl];
            end
            else if (c.mode <= MODE_BRIGHTEN) begin
                if (xl >= w || yt >= h || xr >= w || yb >= h || xr < xl || yb < yt) begin
                    r.clipped = 1'b1;
                end
                else begin
                    for (int y = yt; y <= yb; y++) begin
                        for (int x = xl; x <= xr; x++) begin
                            interior = (y != yt && y != yb && x != xl && x != xr);
                            if (!(c.mode == MODE_OUTLINE && interior)) begin
                                addr = y * w + x;
                                pixels[addr] = shade(c.mode, pixels[addr], c.color);
                            end
                        end
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(rre_rsp_t got);
            rre_rsp_t exp;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: read_value=%02h clipped=%0b",
                             got.read_value, got.clipped);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.read_value !== exp.read_value || got.clipped !== exp.clipped) begin
                if (mismatches < 10)
                    $display("mismatch at %0t: expected %02h/%0b, got %02h/%0b",
                             $realtime, exp.read_value, exp.clipped, got.read_value,
                             got.clipped);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    rre_cmd_t           cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rre_rsp_t           rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    raster_scoreboard raster = new();
    rre_cmd_t         directed_q [$];
    int               sender_idle_pct    = 0;
    int               receiver_stall_pct = 0;
    int               rsp_hold_cycles    = 0;
    int               last_x             = 0;
    int               last_y             = 0;

    rect_raster_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_hold_cycles = rsp_hold_cycles - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(1, 100) > receiver_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_ready)
            raster.check_result(rsp);
    end

    function automatic rre_cmd_t make_command(logic [MODE_W-1:0] mode, int xl, int yt, int xr,
                                              int yb, logic [PIXEL_W-1:0] color);
        rre_cmd_t c;
        c.mode     = mode;
        c.x_left   = COORD_W'(xl);
        c.y_top    = COORD_W'(yt);
        c.x_right  = COORD_W'(xr);
        c.y_bottom = COORD_W'(yb);
        c.color    = color;
        return c;
    endfunction

    function automatic rre_cmd_t random_command();
        rre_cmd_t    c;
        logic [63:0] raw;
        int          w;
        int          h;
        int          r;
        int          xl;
        int          yt;
        int          xr;
        int          yb;
        int          tmp;
        w   = raster.eff_width();
        h   = raster.eff_height();
        r   = $urandom_range(0, 99);
        raw = {$urandom(), $urandom()};
        c   = raw[$bits(rre_cmd_t)-1:0];
        if (w == 0 || h == 0 || r < 8)
            return c;
        if (r < 25)
        begin
            if ($urandom_range(0, 1))
            begin
                xl = last_x + $urandom_range(0, 7);
                yt = last_y + $urandom_range(0, 7);
            end
            else
            begin
                xl = $urandom_range(0, w);
                yt = $urandom_range(0, h);
            end
            c.mode   = MODE_READ;
            c.x_left = COORD_W'(xl);
            c.y_top  = COORD_W'(yt);
            return c;
        end
        xl = $urandom_range(0, w - 1);
        yt = $urandom_range(0, h - 1);
        if ($urandom_range(0, 9) == 0)
        begin
            xr = xl + $urandom_range(0, 31);
            yb = yt + $urandom_range(0, 31);
        end
        else
        begin
            xr = xl + $urandom_range(0, 7);
            yb = yt + $urandom_range(0, 7);
        end
        if (xr >= w)
            xr = w - 1;
        if (yb >= h)
            yb = h - 1;
        if (r < 33)
        begin
            case ($urandom_range(0, 3))
                0: xr = w + $urandom_range(0, 1023 - w);
                1: yb = h + $urandom_range(0, 1023 - h);
                2:
                begin
                    if (xl == xr)
                        xl = xl + 1;
                    else
                    begin
                        tmp = xl;
                        xl  = xr;
                        xr  = tmp;
                    end
                end
                default:
                begin
                    if (yt == yb)
                        yt = yt + 1;
                    else
                    begin
                        tmp = yt;
                        yt  = yb;
                        yb  = tmp;
                    end
                end
            endcase
        end
        last_x = xl;
        last_y = yt;
        return make_command(MODE_W'($urandom_range(MODE_OUTLINE, MODE_BRIGHTEN)), xl, yt, xr,
                            yb, c.color);
    endfunction

    task automatic send_command(input rre_cmd_t word);
        while ($urandom_range(1, 100) <= sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= word;
        do @(posedge clk); while (cmd_ready !== 1'b1);
        raster.note_command(word);
        @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] data;
        mask = (idx == REG_SCREEN_WIDTH) ? 32'h3FF : 32'h1FF;
        data = ($urandom() & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        raster.write_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int send_idle, input int recv_stall);
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        while (directed_q.size() != 0)
            send_command(directed_q.pop_front());
        repeat (count)
            send_command(random_command());
        cmd_valid <= 1'b0;
        while (raster.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_q.push_back(make_command(MODE_READ, 0, 0, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_FILL, 10, 10, 13, 12, 8'hFF));
        directed_q.push_back(make_command(MODE_READ, 10, 10, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_OUTLINE, 20, 20, 25, 24, 8'h5A));
        directed_q.push_back(make_command(MODE_READ, 22, 22, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 20, 22, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_DARKEN, 10, 10, 11, 11, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 10, 10, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_FILL, 30, 30, 31, 30, 8'h3E));
        directed_q.push_back(make_command(MODE_BRIGHTEN, 10, 10, 13, 12, 8'h00));
        directed_q.push_back(make_command(MODE_BRIGHTEN, 30, 30, 31, 30, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 30, 30, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 11, 10, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_OUTLINE, 40, 40, 45, 40, 8'h81));
        directed_q.push_back(make_command(MODE_OUTLINE, 50, 40, 50, 45, 8'h18));
        directed_q.push_back(make_command(MODE_OUTLINE, 319, 199, 319, 199, 8'h80));
        directed_q.push_back(make_command(MODE_READ, 319, 199, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_FILL, 318, 0, 320, 5, 8'h11));
        directed_q.push_back(make_command(MODE_FILL, 0, 199, 0, 200, 8'h22));
        directed_q.push_back(make_command(MODE_DARKEN, 1023, 1023, 1023, 1023, 8'hFF));
        directed_q.push_back(make_command(MODE_BRIGHTEN, 5, 5, 4, 6, 8'h00));
        directed_q.push_back(make_command(MODE_OUTLINE, 5, 6, 6, 5, 8'h33));
        directed_q.push_back(make_command(MODE_READ, 320, 0, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 1023, 1023, 1023, 1023, 8'hFF));
        for (int m = MODE_BRIGHTEN + 1; m < 2 ** MODE_W; m++)
            directed_q.push_back(make_command(MODE_W'(m), 1, 1, 9, 9, 8'hC3));
        run_phase(400, 0, 0);

        write_register(REG_SCREEN_WIDTH, 16);
        write_register(REG_SCREEN_HEIGHT, 8);
        run_phase(300, 87, 0);

        write_register(REG_SCREEN_WIDTH, 1023);
        write_register(REG_SCREEN_HEIGHT, 511);
        directed_q.push_back(make_command(MODE_FILL, 0, 0, 511, 255, 8'hA7));
        directed_q.push_back(make_command(MODE_READ, 511, 255, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_OUTLINE, 0, 0, 511, 255, 8'h5C));
        directed_q.push_back(make_command(MODE_READ, 0, 128, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 256, 128, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_DARKEN, 500, 250, 511, 255, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 511, 255, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_BRIGHTEN, 0, 0, 3, 3, 8'h00));
        directed_q.push_back(make_command(MODE_READ, 0, 0, 0, 0, 8'h00));
        directed_q.push_back(make_command(MODE_FILL, 0, 0, 512, 0, 8'h44));
        directed_q.push_back(make_command(MODE_READ, 512, 255, 0, 0, 8'h00));
        run_phase(300, 0, 87);

        write_register(REG_SCREEN_WIDTH, 1);
        write_register(REG_SCREEN_HEIGHT, 1);
        run_phase(150, 32, 32);

        write_register(REG_SCREEN_WIDTH, 0);
        write_register(REG_SCREEN_HEIGHT, 0);
        run_phase(60, 32, 32);

        write_register(REG_SCREEN_WIDTH, 512);
        write_register(REG_SCREEN_HEIGHT, 256);
        rsp_hold_cycles = 600;
        run_phase(400, 0, 0);

        write_register(REG_SCREEN_WIDTH, 100);
        write_register(REG_SCREEN_HEIGHT, 37);
        run_phase(300, 32, 32);

        if (raster.mismatches == 0 && raster.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
